>>> sv/nsfe_pkg.sv
// ---------------------------------------------------------------------------
// nsfe_pkg: shared types and constants of the NMEA sentence filter
// Holds the phase encoding, register indexes, reset values and the
// read request that the controller hands to the output pipeline.
// ---------------------------------------------------------------------------
package nsfe_pkg;

	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned CFG_IDX_W = 2;

	// Store position that must hold the first type character.
	localparam int unsigned TYPE1_POS = 4;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_START_CHAR  = 2'd0,
		CFG_TYPE_FIRST  = 2'd1,
		CFG_TYPE_SECOND = 2'd2,
		CFG_END_CHAR    = 2'd3
	} cfg_reg_t;

	localparam logic [BYTE_W-1:0] START_CHAR_RST  = 8'd36;
	localparam logic [BYTE_W-1:0] TYPE_FIRST_RST  = 8'd71;
	localparam logic [BYTE_W-1:0] TYPE_SECOND_RST = 8'd65;
	localparam logic [BYTE_W-1:0] END_CHAR_RST    = 8'd10;

	typedef enum logic [2:0] {
		PH_HUNT  = 3'd0,
		PH_TYPE1 = 3'd1,
		PH_TYPE2 = 3'd2,
		PH_LOAD  = 3'd3,
		PH_READY = 3'd4
	} phase_t;

	// Event codes carried in the mode field of a command item.
	localparam logic MODE_RX = 1'b0;
	localparam logic MODE_TX = 1'b1;

	// Read issued to the buffer this cycle, and whether it is the final byte.
	typedef struct packed {
		logic fire;
		logic last;
	} echo_req_t;

endpackage

>>> sv/nsfe_if.sv
// ---------------------------------------------------------------------------
// nsfe_if: channel interfaces of the NMEA sentence filter
// The command channel carries UART events; the echo channel carries the
// stored sentence bytes back to the transmitter.
// ---------------------------------------------------------------------------
interface nsfe_cmd_if;
	logic       valid;
	logic       ready;
	logic       mode;
	logic [7:0] rx_byte;

	modport source (output valid, output mode, output rx_byte, input ready);
	modport sink   (input valid, input mode, input rx_byte, output ready);
endinterface

interface nsfe_echo_if;
	logic       valid;
	logic       ready;
	logic [7:0] tx_byte;
	logic       last_byte;

	modport source (output valid, output tx_byte, output last_byte, input ready);
	modport sink   (input valid, input tx_byte, input last_byte, output ready);
endinterface

>>> sv/nmea_sentence_filter_echo.sv
// ---------------------------------------------------------------------------
// nmea_sentence_filter_echo: NMEA sentence filter with echo
// Keeps UART sentences of one configured type in a byte buffer and plays
// them back one byte per transmitter-ready event.
// ---------------------------------------------------------------------------
//
//  Channel | Role     | Payload                | Handshake
//  --------+----------+------------------------+--------------------------
//  cmd     | sink     | mode, rx_byte          | valid/ready, item on both
//  echo    | source   | tx_byte, last_byte     | valid/ready, item on both
//  cfg     | write    | cfg_index, cfg_data    | cfg_we, taken every edge
//
// One command item is accepted per cycle while cmd is ready. An echo item
// for a transmitter-ready item goes through the buffer read into the read
// stage and then into the output register.
// The rate is set by the single write port and single read port of the
// byte buffer; a receive and an echo never use the same port together.
// arst_n clears the phase, counters, pending flag and pipeline valids; the
// buffer contents are not cleared and need no clearing pass.
// A stalled echo channel holds the output register; cmd stays ready as
// long as the read stage is free or can drain into the output register.
// ---------------------------------------------------------------------------
module nmea_sentence_filter_echo
	import nsfe_pkg::*;
#(
	parameter int unsigned BUFFER_DEPTH = 128
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [BYTE_W-1:0]    cfg_data,
	nsfe_cmd_if.sink             cmd,
	nsfe_echo_if.source          echo
);

	localparam int unsigned AW = $clog2(BUFFER_DEPTH);

	logic              cmd_take;
	logic              mem_we;
	logic [AW-1:0]     mem_waddr, mem_raddr;
	logic [BYTE_W-1:0] mem_wdata, mem_rdata;
	echo_req_t         rd;

	// Read stage: the buffer's registered read data plus these flags.
	logic              valid_s1, last_s1, s1_move;

	// Output register.
	logic              out_valid_q, out_last_q;
	logic [BYTE_W-1:0] out_byte_q;

	assign cmd_take = cmd.valid && cmd.ready;

	nsfe_ctrl #(
		.DEPTH (BUFFER_DEPTH),
		.AW    (AW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.take      (cmd_take),
		.mode      (cmd.mode),
		.rx_byte   (cmd.rx_byte),
		.we        (mem_we),
		.waddr     (mem_waddr),
		.wdata     (mem_wdata),
		.raddr     (mem_raddr),
		.rd        (rd)
	);

	// Writes only happen while no sentence is pending and reads only while
	// one is, so a read never meets a write to the same entry in one cycle.
	// A read right after the closing write sees that write already stored.
	nsfe_buffer #(
		.DEPTH (BUFFER_DEPTH),
		.AW    (AW)
	) u_buffer (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (mem_waddr),
		.wdata   (mem_wdata),
		.re      (rd.fire),
		.raddr   (mem_raddr),
		.rdata_q (mem_rdata)
	);

	// The read stage drains whenever the output register is empty or being
	// emptied. The buffer only reads on a new request, so its data holds
	// while the read stage is stuck.
	assign s1_move   = valid_s1 && (!out_valid_q || echo.ready);
	assign cmd.ready = !valid_s1 || s1_move;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			last_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rd.fire) begin
				valid_s1 <= 1'b1;
				last_s1  <= rd.last;
			end else if (s1_move) begin
				valid_s1 <= 1'b0;
			end
			if (s1_move) begin
				out_valid_q <= 1'b1;
			end else if (echo.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			out_byte_q <= mem_rdata;
			out_last_q <= last_s1;
		end
	end

	assign echo.valid     = out_valid_q;
	assign echo.tx_byte   = out_byte_q;
	assign echo.last_byte = out_last_q;

	// A new read must never overwrite a read stage that cannot drain.
	a_no_s1_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		rd.fire |-> (!valid_s1 || s1_move))
		else $error("buffer read issued over a stalled read stage");

	// The final byte clears the pending flag, so no read follows it at once.
	a_last_ends_echo: assert property (@(posedge clk) disable iff (!arst_n)
		(rd.fire && rd.last) |=> !rd.fire)
		else $error("echo continued past the final byte");

	// A stuck read stage keeps its item.
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !s1_move) |=> valid_s1)
		else $error("read stage lost an item while stalled");

endmodule

>>> sv/nsfe_buffer.sv
// ---------------------------------------------------------------------------
// nsfe_buffer: sentence byte store
// Simple dual-port synchronous memory, one write and one read per cycle,
// read data registered.
// ---------------------------------------------------------------------------
module nsfe_buffer
	import nsfe_pkg::*;
#(
	parameter int unsigned DEPTH = 128,
	parameter int unsigned AW    = 7
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  logic [BYTE_W-1:0] wdata,
	input  logic              re,
	input  logic [AW-1:0]     raddr,
	output logic [BYTE_W-1:0] rdata_q
);

	logic [BYTE_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

endmodule

>>> sv/nsfe_ctrl.sv
// ---------------------------------------------------------------------------
// nsfe_ctrl: sentence filter control
// Holds the configuration registers, the phase machine, the write count,
// the read index and the pending flag, and drives the buffer ports.
// ---------------------------------------------------------------------------
module nsfe_ctrl
	import nsfe_pkg::*;
#(
	parameter int unsigned DEPTH = 128,
	parameter int unsigned AW    = 7
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [BYTE_W-1:0]    cfg_data,
	input  logic                 take,
	input  logic                 mode,
	input  logic [BYTE_W-1:0]    rx_byte,
	output logic                 we,
	output logic [AW-1:0]        waddr,
	output logic [BYTE_W-1:0]    wdata,
	output logic [AW-1:0]        raddr,
	output echo_req_t            rd
);

	localparam int unsigned CW = AW + 1;

	logic [BYTE_W-1:0] start_char_q, type_first_q, type_second_q, end_char_q;
	phase_t            phase_q, phase_d;
	logic [CW-1:0]     wcount_q, wcount_eff, wcount_d;
	logic [AW-1:0]     rindex_q;
	logic [CW-1:0]     rindex_inc;
	logic              pending_q;
	logic              rx_take, clear_count, set_pending, has_room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_char_q  <= START_CHAR_RST;
			type_first_q  <= TYPE_FIRST_RST;
			type_second_q <= TYPE_SECOND_RST;
			end_char_q    <= END_CHAR_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				CFG_START_CHAR:  start_char_q  <= cfg_data;
				CFG_TYPE_FIRST:  type_first_q  <= cfg_data;
				CFG_TYPE_SECOND: type_second_q <= cfg_data;
				CFG_END_CHAR:    end_char_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Received bytes are ignored while a sentence waits to be echoed.
	assign rx_take = take && (mode == MODE_RX) && !pending_q;

	// Next phase.
	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			PH_HUNT: begin
				if (rx_byte == start_char_q) phase_d = PH_TYPE1;
			end
			PH_TYPE1: begin
				if (wcount_q == CW'(TYPE1_POS) && rx_byte == type_first_q) begin
					phase_d = PH_TYPE2;
				end else if (wcount_q >= CW'(TYPE1_POS)) begin
					phase_d = PH_HUNT;
				end
			end
			PH_TYPE2: begin
				phase_d = (rx_byte == type_second_q) ? PH_LOAD : PH_HUNT;
			end
			PH_LOAD: begin
				if (rx_byte == end_char_q) phase_d = PH_READY;
			end
			PH_READY: phase_d = PH_HUNT;
			default:  phase_d = PH_HUNT;
		endcase
	end

	// Phase outputs.
	always_comb begin
		clear_count = 1'b0;
		set_pending = 1'b0;
		case (phase_q)
			PH_HUNT: clear_count = (rx_byte == start_char_q);
			PH_LOAD: set_pending = (rx_byte == end_char_q);
			default: ;
		endcase
	end

	// The store position is taken after a start character has cleared it.
	assign wcount_eff = clear_count ? '0 : wcount_q;
	assign has_room   = wcount_eff < CW'(DEPTH);
	assign wcount_d   = has_room ? wcount_eff + CW'(1) : wcount_eff;

	assign we    = rx_take && has_room;
	assign waddr = wcount_eff[AW-1:0];
	assign wdata = rx_byte;

	assign rindex_inc = {1'b0, rindex_q} + CW'(1);
	assign raddr      = rindex_q;
	assign rd.fire    = take && (mode == MODE_TX) && pending_q;
	assign rd.last    = rindex_inc >= wcount_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HUNT;
			wcount_q  <= '0;
			rindex_q  <= '0;
			pending_q <= 1'b0;
		end else begin
			if (rx_take) begin
				phase_q  <= phase_d;
				wcount_q <= wcount_d;
				if (set_pending) pending_q <= 1'b1;
			end
			if (rd.fire) begin
				if (rd.last) begin
					rindex_q  <= '0;
					pending_q <= 1'b0;
				end else begin
					rindex_q <= rindex_inc[AW-1:0];
				end
			end
		end
	end

endmodule
